>>> hw/rtl/fxalu_pkg.sv
// shared types, op codes and constants for the fixed-point alu
`default_nettype none

package fxalu_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_BITS_DEF = 8;

  typedef enum logic [4:0] {
    OP_ADD        = 5'd0,
    OP_SUB        = 5'd1,
    OP_MUL        = 5'd2,
    OP_DIV        = 5'd3,
    OP_GT         = 5'd4,
    OP_LT         = 5'd5,
    OP_GE         = 5'd6,
    OP_LE         = 5'd7,
    OP_EQ         = 5'd8,
    OP_NE         = 5'd9,
    OP_MIN        = 5'd10,
    OP_MAX        = 5'd11,
    OP_INC        = 5'd12,
    OP_DEC        = 5'd13,
    OP_FROM_INT   = 5'd14,
    OP_TO_INT     = 5'd15,
    OP_FROM_FLOAT = 5'd16,
    OP_TO_FLOAT   = 5'd17
  } op_t;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_DIV0  = 2'd1;
  localparam logic [1:0] ERR_FLOAT = 2'd2;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [4:0]        op;
    logic [DATA_W-1:0] res;
    logic              flag;
    logic [DATA_W-1:0] fout;
    logic [1:0]        err;
  } misc_t;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic [1:0]        err;
    logic [DATA_W-1:0] fout;
  } cvt_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/fxalu_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module fxalu_div import fxalu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     adv,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic signed [DATA_W-1:0] b,
  output logic             [DATA_W-1:0] quo,
  output logic                          neg,
  output logic                          dz
);

  localparam int NW = DATA_W + FRAC_BITS;

  logic [NW-1:0]     num [NW+1];
  logic [DATA_W-1:0] rem [NW+1];
  logic [DATA_W-1:0] den [NW+1];
  logic [DATA_W-1:0] q   [NW+1];
  logic              sgn [NW+1];
  logic              zer [NW+1];

  logic [DATA_W-1:0] amag;
  logic [DATA_W-1:0] bmag;

  assign amag = a[DATA_W-1] ? (~a + 1'b1) : a;
  assign bmag = b[DATA_W-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (adv) begin
      num[0] <= {amag, {FRAC_BITS{1'b0}}};
      rem[0] <= '0;
      den[0] <= bmag;
      q[0]   <= '0;
      sgn[0] <= a[DATA_W-1] ^ b[DATA_W-1];
      zer[0] <= (b == '0);
    end
  end

  for (genvar i = 1; i <= NW; i++) begin : g_st
    logic [DATA_W:0]   shr;
    logic [DATA_W+1:0] diff;
    logic              ge;

    assign shr  = {rem[i-1], num[i-1][NW-1]};
    assign diff = {1'b0, shr} - {2'b00, den[i-1]};
    assign ge   = !diff[DATA_W+1];

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i] <= ge ? diff[DATA_W-1:0] : shr[DATA_W-1:0];
        num[i] <= {num[i-1][NW-2:0], 1'b0};
        den[i] <= den[i-1];
        q[i]   <= {q[i-1][DATA_W-2:0], ge};
        sgn[i] <= sgn[i-1];
        zer[i] <= zer[i-1];
      end
    end
  end

  assign quo = q[NW];
  assign neg = sgn[NW];
  assign dz  = zer[NW];

endmodule

`default_nettype wire

>>> hw/rtl/fxalu_cvt.sv
// four-stage float/fixed converters
`default_nettype none

module fxalu_cvt import fxalu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     adv,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic        [DATA_W-1:0] fin,
  output cvt_out_t                      cout
);

  // float to fixed, stage 1: decode and shift amounts
  logic              k1_neg, k1_nan, k1_inf, k1_big, k1_left, k1_zero;
  logic [3:0]        k1_lsh;
  logic [4:0]        k1_rsh;
  logic [23:0]       k1_sig;
  // stage 2: shifted magnitude and round bit
  logic              k2_neg, k2_nan, k2_inf, k2_big, k2_rnd;
  logic [DATA_W:0]   k2_mag;
  // stage 3: rounded magnitude
  logic              k3_neg, k3_nan, k3_inf, k3_big;
  logic [DATA_W:0]   k3_mag;

  // fixed to float pipeline
  logic              t1_neg;
  logic [DATA_W-1:0] t1_mag;
  logic              t2_neg, t2_zero;
  logic [DATA_W-1:0] t2_mag;
  logic [4:0]        t2_p;
  logic              t3_neg, t3_zero, t3_g, t3_s;
  logic [23:0]       t3_mant;
  logic [4:0]        t3_p;

  logic [7:0]        e_raw;
  logic [8:0]        e_adj;
  logic [23:0]       sig_c;
  logic signed [9:0] sh;
  logic [9:0]        rneg;
  logic [4:0]        pz;
  logic [DATA_W-1:0] norm;
  logic              inc;
  logic [24:0]       mr;
  logic [5:0]        pf;
  logic [8:0]        ex;
  logic [DATA_W-1:0] fx_res;
  logic [1:0]        fx_err;

  assign e_raw = fin[30:23];
  assign e_adj = (e_raw == 8'd0) ? 9'd1 : {1'b0, e_raw};
  assign sig_c = (e_raw == 8'd0) ? {1'b0, fin[22:0]} : {1'b1, fin[22:0]};
  assign sh    = $signed({1'b0, e_adj}) - 10'sd150 + 10'(FRAC_BITS);
  assign rneg  = 10'(-sh);

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_neg  <= fin[31];
      k1_nan  <= (e_raw == 8'hFF) && (fin[22:0] != '0);
      k1_inf  <= (e_raw == 8'hFF) && (fin[22:0] == '0);
      k1_big  <= sh > 10'sd8;
      k1_left <= sh >= 10'sd0;
      k1_zero <= (sh < 10'sd0) && (rneg > 10'd24);
      k1_lsh  <= sh[3:0];
      k1_rsh  <= rneg[4:0];
      k1_sig  <= sig_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k2_neg <= k1_neg;
      k2_nan <= k1_nan;
      k2_inf <= k1_inf;
      k2_big <= k1_big;
      if (k1_left) begin
        k2_mag <= (DATA_W+1)'(k1_sig) << k1_lsh;
        k2_rnd <= 1'b0;
      end else if (k1_zero) begin
        k2_mag <= '0;
        k2_rnd <= 1'b0;
      end else begin
        k2_mag <= (DATA_W+1)'(k1_sig >> k1_rsh);
        k2_rnd <= k1_sig[k1_rsh - 5'd1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k3_neg <= k2_neg;
      k3_nan <= k2_nan;
      k3_inf <= k2_inf;
      k3_big <= k2_big;
      k3_mag <= k2_mag + (DATA_W+1)'(k2_rnd);
    end
  end

  always_comb begin
    fx_res = '0;
    fx_err = ERR_OK;
    if (k3_nan) begin
      fx_err = ERR_FLOAT;
    end else if (k3_inf || k3_big) begin
      fx_res = k3_neg ? SAT_MIN : SAT_MAX;
      fx_err = ERR_FLOAT;
    end else if (k3_neg) begin
      if (k3_mag > {1'b0, SAT_MIN}) begin
        fx_res = SAT_MIN;
        fx_err = ERR_FLOAT;
      end else begin
        fx_res = DATA_W'(~k3_mag + 1'b1);
      end
    end else if (k3_mag > {1'b0, SAT_MAX}) begin
      fx_res = SAT_MAX;
      fx_err = ERR_FLOAT;
    end else begin
      fx_res = k3_mag[DATA_W-1:0];
    end
  end

  // leading one search over the magnitude
  always_comb begin
    pz = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (t1_mag[i]) pz = 5'(i);
    end
  end

  assign norm = t2_mag << (~t2_p);
  assign inc  = t3_g && (t3_s || t3_mant[0]);
  assign mr   = {1'b0, t3_mant} + 25'(inc);
  assign pf   = {1'b0, t3_p} + 6'(mr[24]);
  assign ex   = 9'(pf) + 9'd127 - 9'(FRAC_BITS);

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_neg  <= a[DATA_W-1];
      t1_mag  <= a[DATA_W-1] ? (~a + 1'b1) : a;
      t2_neg  <= t1_neg;
      t2_zero <= (t1_mag == '0);
      t2_mag  <= t1_mag;
      t2_p    <= pz;
      t3_neg  <= t2_neg;
      t3_zero <= t2_zero;
      t3_p    <= t2_p;
      t3_mant <= norm[31:8];
      t3_g    <= norm[7];
      t3_s    <= |norm[6:0];
      cout.res <= fx_res;
      cout.err <= fx_err;
      if (t3_zero) begin
        cout.fout <= '0;
      end else begin
        // mantissa overflow leaves the low 23 bits zero
        cout.fout <= {t3_neg, ex[7:0], mr[22:0]};
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fixed_point_q24_8_alu.sv
// top level of the signed fixed-point alu
`default_nettype none

// Signed fixed-point ALU on 32-bit words with FRAC_BITS fraction bits. One word
// is taken in every cycle unless in_stall is high, and one word comes out for
// each, in order. The divider resolves one quotient bit per pipeline stage;
// all other operations travel down a matching delay line. The whole pipeline
// advances together: in_stall rises only in reset or while a finished word
// waits on out_stall.

module fixed_point_q24_8_alu import fxalu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic        [4:0]        req_type,
  input  wire logic signed [DATA_W-1:0] operand_a,
  input  wire logic signed [DATA_W-1:0] operand_b,
  input  wire logic        [DATA_W-1:0] float_in,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      result,
  output logic                          flag,
  output logic        [DATA_W-1:0]      float_out,
  output logic        [1:0]             error
);

  localparam int NW   = DATA_W + FRAC_BITS;
  localparam int DLAT = NW + 1;
  localparam int DD   = DLAT - 4;

  logic adv;

  logic                     s0_valid;
  logic [4:0]               s0_op;
  logic signed [DATA_W-1:0] s0_a;
  logic signed [DATA_W-1:0] s0_b;
  logic [DATA_W-1:0]        s0_f;

  logic vld [DLAT+1];

  misc_t                    m1, m2, m3, m4, m1_next, m2_next, mrg;
  misc_t                    dl [DD];
  logic signed [2*DATA_W-1:0] prod;

  cvt_out_t          cvo;
  logic [DATA_W-1:0] dq;
  logic              dneg, ddz;
  misc_t             fin_rec;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = rst || !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_op <= req_type;
      s0_a  <= operand_a;
      s0_b  <= operand_b;
      s0_f  <= float_in;
    end
  end

  assign vld[0] = s0_valid;
  for (genvar i = 1; i <= DLAT; i++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_comb begin
    m1_next      = '0;
    m1_next.op   = s0_op;
    m1_next.err  = ERR_OK;
    case (op_t'(s0_op))
      OP_ADD:      m1_next.res  = s0_a + s0_b;
      OP_SUB:      m1_next.res  = s0_a - s0_b;
      OP_GT:       m1_next.flag = s0_a > s0_b;
      OP_LT:       m1_next.flag = s0_a < s0_b;
      OP_GE:       m1_next.flag = s0_a >= s0_b;
      OP_LE:       m1_next.flag = s0_a <= s0_b;
      OP_EQ:       m1_next.flag = s0_a == s0_b;
      OP_NE:       m1_next.flag = s0_a != s0_b;
      OP_MIN:      m1_next.res  = (s0_a < s0_b) ? s0_a : s0_b;
      OP_MAX:      m1_next.res  = (s0_a > s0_b) ? s0_a : s0_b;
      OP_INC:      m1_next.res  = s0_a + 1'b1;
      OP_DEC:      m1_next.res  = s0_a - 1'b1;
      OP_FROM_INT: m1_next.res  = s0_a << FRAC_BITS;
      OP_TO_INT:   m1_next.res  = s0_a >>> FRAC_BITS;
      default:     m1_next.res  = '0;
    endcase
  end

  always_comb begin
    m2_next = m1;
    if (m1.op == OP_MUL) begin
      m2_next.res = DATA_W'(prod >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1   <= m1_next;
      prod <= s0_a * s0_b;
      m2   <= m2_next;
      m3   <= m2;
      m4   <= m3;
    end
  end

  fxalu_cvt #(.FRAC_BITS(FRAC_BITS)) u_cvt (
    .clk  (clk),
    .adv  (adv),
    .a    (s0_a),
    .fin  (s0_f),
    .cout (cvo)
  );

  always_comb begin
    mrg = m4;
    if (m4.op == OP_FROM_FLOAT) begin
      mrg.res = cvo.res;
      mrg.err = cvo.err;
    end else if (m4.op == OP_TO_FLOAT) begin
      mrg.fout = cvo.fout;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl[0] <= mrg;
    end
  end

  for (genvar i = 1; i < DD; i++) begin : g_dl
    always_ff @(posedge clk) begin
      if (adv) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  fxalu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .adv (adv),
    .a   (s0_a),
    .b   (s0_b),
    .quo (dq),
    .neg (dneg),
    .dz  (ddz)
  );

  always_comb begin
    fin_rec = dl[DD-1];
    if (fin_rec.op == OP_DIV) begin
      fin_rec.res = ddz ? '0 : (dneg ? (~dq + 1'b1) : dq);
      fin_rec.err = ddz ? ERR_DIV0 : ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[DLAT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result    <= fin_rec.res;
      flag      <= fin_rec.flag;
      float_out <= fin_rec.fout;
      error     <= fin_rec.err;
    end
  end

endmodule

`default_nettype wire

>>> tb/fixed_point_q24_8_alu_tb.sv
// testbench for the fixed-point alu: directed, backpressure and random words checked against a predictor
`timescale 1ns / 100ps

module fixed_point_q24_8_alu_tb import fxalu_pkg::*;;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = FRAC + 60;

  typedef struct {
    logic [DATA_W-1:0] res;
    logic              flag;
    logic [DATA_W-1:0] fout;
    logic [1:0]        err;
  } alu_out_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic        [4:0]        req_type = '0;
  logic signed [DATA_W-1:0] operand_a = '0;
  logic signed [DATA_W-1:0] operand_b = '0;
  logic        [DATA_W-1:0] float_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] result;
  logic                     flag;
  logic        [DATA_W-1:0] float_out;
  logic        [1:0]        error;

  alu_out_t pending_q[$];
  int       fail_count = 0;
  int       idle_cycles = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b1;
  bit       hold_req = 1'b0;

  fixed_point_q24_8_alu uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .operand_a(operand_a), .operand_b(operand_b), .float_in(float_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .flag(flag), .float_out(float_out), .error(error)
  );

  always #1 clk = ~clk;

  // ieee single to fixed, halves away from zero, saturating
  function automatic alu_out_t float_to_fixed(logic [31:0] f);
    alu_out_t    o;
    logic [63:0] sig, mag, rem_bits, half;
    int          ex, sh, r;
    o = '{res: '0, flag: 1'b0, fout: '0, err: ERR_OK};
    ex = f[30:23];
    if (ex == 255) begin
      o.err = ERR_FLOAT;
      o.res = (f[22:0] != 0) ? '0 : (f[31] ? SAT_MIN : SAT_MAX);
      return o;
    end
    if (ex == 0) begin
      sig = {41'd0, f[22:0]};
      ex = 1;
    end else begin
      sig = {40'd0, 1'b1, f[22:0]};
    end
    sh = ex - 150 + FRAC;
    if (sh >= 0) begin
      mag = (sh > 40) ? (64'd1 << 40) : (sig << sh);
    end else begin
      r = -sh;
      if (r > 25) begin
        mag = 0;
      end else begin
        half = 64'd1 << (r - 1);
        rem_bits = sig & ((64'd1 << r) - 1);
        mag = (sig >> r) + ((rem_bits >= half) ? 64'd1 : 64'd0);
      end
    end
    if (f[31]) begin
      if (mag > 64'h8000_0000) begin
        o.err = ERR_FLOAT;
        o.res = SAT_MIN;
      end else begin
        o.res = 32'(64'd0 - mag);
      end
    end else if (mag > 64'h7FFF_FFFF) begin
      o.err = ERR_FLOAT;
      o.res = SAT_MAX;
    end else begin
      o.res = mag[31:0];
    end
    return o;
  endfunction

  // fixed to ieee single, nearest even
  function automatic logic [31:0] fixed_to_float(logic signed [31:0] a);
    logic [63:0] mag, mant, half, rem_bits;
    logic        neg;
    int          p, r;
    neg = a[31];
    mag = neg ? 64'(-longint'(a)) : 64'(a);
    if (mag == 0) return '0;
    p = 31;
    while (mag[p] == 1'b0) p--;
    if (p <= 23) begin
      mant = mag << (23 - p);
    end else begin
      r = p - 23;
      half = 64'd1 << (r - 1);
      rem_bits = mag & ((64'd1 << r) - 1);
      mant = mag >> r;
      if (rem_bits > half || (rem_bits == half && mant[0])) mant++;
      if (mant[24]) begin
        mant = mant >> 1;
        p++;
      end
    end
    return {neg, 8'(p - FRAC + 127), mant[22:0]};
  endfunction

  function automatic alu_out_t alu_predict(logic [4:0] op, logic signed [31:0] a,
                                           logic signed [31:0] b, logic [31:0] f);
    alu_out_t o;
    longint   prod, num;
    o = '{res: '0, flag: 1'b0, fout: '0, err: ERR_OK};
    case (op)
      OP_ADD: o.res = a + b;
      OP_SUB: o.res = a - b;
      OP_MUL: begin
        prod = longint'(a) * longint'(b);
        o.res = 32'(prod >>> FRAC);
      end
      OP_DIV: begin
        if (b == 0) begin
          o.err = ERR_DIV0;
        end else begin
          num = longint'(a) <<< FRAC;
          o.res = 32'(num / longint'(b));
        end
      end
      OP_GT: o.flag = a > b;
      OP_LT: o.flag = a < b;
      OP_GE: o.flag = a >= b;
      OP_LE: o.flag = a <= b;
      OP_EQ: o.flag = a == b;
      OP_NE: o.flag = a != b;
      OP_MIN: o.res = (a < b) ? a : b;
      OP_MAX: o.res = (a > b) ? a : b;
      OP_INC: o.res = a + 1;
      OP_DEC: o.res = a - 1;
      OP_FROM_INT: o.res = a << FRAC;
      OP_TO_INT: o.res = a >>> FRAC;
      OP_FROM_FLOAT: o = float_to_fixed(f);
      OP_TO_FLOAT: o.fout = fixed_to_float(a);
      default: ;
    endcase
    return o;
  endfunction

  // offer one word and hold it until taken
  task automatic send_word(logic [4:0] op, logic [31:0] a, logic [31:0] b, logic [31:0] f);
    in_valid <= 1'b1;
    req_type <= op;
    operand_a <= a;
    operand_b <= b;
    float_in <= f;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(alu_predict(op, a, b, f));
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'h1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return 32'($urandom_range(0, 4095)) - 32'd2048;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_float();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return {1'($urandom), 8'($urandom_range(100, 165)), 23'($urandom)};
  endfunction

  task automatic test_directed();
    send_word(OP_ADD, 32'h7FFF_FFFF, 32'h1, 0);
    send_word(OP_SUB, 32'h8000_0000, 32'h1, 0);
    send_word(OP_MUL, 32'hFFFF_FE80, 32'h0000_0280, 0);
    send_word(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0);
    send_word(OP_DIV, 32'h0000_0500, 32'h0, 0);
    send_word(OP_DIV, 32'h8000_0000, 32'h1, 0);
    send_word(OP_DIV, 32'hFFFF_FF01, 32'h0000_0300, 0);
    send_word(OP_GT, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_word(OP_LT, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_word(OP_GE, 32'h5, 32'h5, 0);
    send_word(OP_LE, 32'h6, 32'h5, 0);
    send_word(OP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(OP_NE, 32'h0, 32'h0, 0);
    send_word(OP_MIN, 32'hFFFF_FFF0, 32'h10, 0);
    send_word(OP_MAX, 32'hFFFF_FFF0, 32'h10, 0);
    send_word(OP_INC, 32'h7FFF_FFFF, 0, 0);
    send_word(OP_DEC, 32'h8000_0000, 0, 0);
    send_word(OP_FROM_INT, 32'h00FF_FFFF, 0, 0);
    send_word(OP_TO_INT, 32'hFFFF_FE7F, 0, 0);
    // nan, -inf, exact most-negative, overflow, negative zero, subnormal, half rounding
    send_word(OP_FROM_FLOAT, 0, 0, 32'h7FC0_0001);
    send_word(OP_FROM_FLOAT, 0, 0, 32'hFF80_0000);
    send_word(OP_FROM_FLOAT, 0, 0, 32'hCB00_0000);
    send_word(OP_FROM_FLOAT, 0, 0, 32'h4B00_0000);
    send_word(OP_FROM_FLOAT, 0, 0, 32'h8000_0000);
    send_word(OP_FROM_FLOAT, 0, 0, 32'h0000_0001);
    send_word(OP_FROM_FLOAT, 0, 0, 32'hBB00_0000);
    send_word(OP_TO_FLOAT, 32'h0, 0, 0);
    send_word(OP_TO_FLOAT, 32'h8000_0000, 0, 0);
    send_word(OP_TO_FLOAT, 32'h7FFF_FFFF, 0, 0);
    send_word(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic random_word();
    logic [4:0] op;
    op = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(18, 31)) : 5'($urandom_range(0, 17));
    send_word(op, pick_operand(), pick_operand(), pick_float());
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (120) random_word();
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    repeat (600) random_word();
  endtask

  // receiver: long hold on request, otherwise stalls with a drifting rate
  initial begin
    int stall_pct;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 80);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    alu_out_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          $error("unexpected word: result %h", result);
          fail_count++;
        end else begin
          want = pending_q.pop_front();
          if (result !== want.res) begin
            $error("result: expected %h, got %h", want.res, result);
            fail_count++;
          end
          if (flag !== want.flag) begin
            $error("flag: expected %b, got %b", want.flag, flag);
            fail_count++;
          end
          if (float_out !== want.fout) begin
            $error("float_out: expected %h, got %h", want.fout, float_out);
            fail_count++;
          end
          if (error !== want.err) begin
            $error("error: expected %0d, got %0d", want.err, error);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
